// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NTCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntcm assertion failed");

// next-cycle implication
`define NTCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntcm assertion failed");

`endif

// File: hdl/ntcm_pkg.sv
`timescale 1ns / 1ps

package ntcm_pkg;

    localparam int TIME_W     = 32;
    localparam int MV_W       = 12;
    localparam int TEMP_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // sensor status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OPEN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd7;

    // ln(2) in Q28 and 0 C in centikelvin
    localparam logic [27:0] LN2_Q28   = 28'd186065279;
    localparam logic [15:0] ZERO_C_CK = 16'd27315;

    // which operand the log unit works on
    typedef enum logic [1:0] {
        LOG_RATIO,
        LOG_REST,
        LOG_MV
    } log_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOG_INIT,
        S_LOG_NORM,
        S_LOG_MUL,
        S_LOG_SQ,
        S_LOG_ACC,
        S_LN_A,
        S_LN_B,
        S_LN_C,
        S_LN_D,
        S_DEN_A,
        S_DEN_B,
        S_DEN_C,
        S_DEN_D,
        S_NUM_A,
        S_NUM_B,
        S_DIV,
        S_WIN,
        S_EMA_A,
        S_EMA_B,
        S_DONE
    } state_t;

endpackage

// File: hdl/ntcm_ifs.sv
`timescale 1ns / 1ps

interface ntcm_in_if;
    logic                         valid;
    logic                         ready;
    logic [ntcm_pkg::TIME_W-1:0]  now_ms;
    logic [ntcm_pkg::MV_W-1:0]    sample_mv;
    modport source (output valid, now_ms, sample_mv, input ready);
    modport sink (input valid, now_ms, sample_mv, output ready);
endinterface

interface ntcm_out_if;
    logic                           valid;
    logic                           ready;
    logic [ntcm_pkg::STATUS_W-1:0]  sensor_status;
    logic signed [ntcm_pkg::TEMP_W-1:0] temp_centi_c;
    logic                           sample_taken;
    logic [ntcm_pkg::TIME_W-1:0]    last_sample_ms;
    modport source (output valid, sensor_status, temp_centi_c, sample_taken, last_sample_ms,
                    input ready);
    modport sink (input valid, sensor_status, temp_centi_c, sample_taken, last_sample_ms,
                  output ready);
endinterface

interface ntcm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ntcm_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [ntcm_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, reg_index, data, input ready);
    modport sink (input valid, reg_index, data, output ready);
endinterface

// File: hdl/ntc_thermistor_temperature_monitor.sv
`timescale 1ns / 1ps
// channel   dir   payload                                              handshake
// in_ch     in    now_ms[31:0], sample_mv[11:0]                        valid/ready
// out_ch    out   sensor_status[1:0], temp_centi_c[15:0] (signed),     valid/ready
//                 sample_taken, last_sample_ms[31:0]
// cfg       in    reg_index[2:0], data[23:0]                           valid/ready, always ready
//
// a skipped, open or shorted sample, or one non-physical at input, goes straight to done
// a converted sample runs three base-2 logs (a normalising shift of up to 30
// bits, then 28 squarings, each a multiply and a square step) and a
// 56-step restoring divide, all sequenced over one shared 33x33 multiplier
// in_ch is ready only in idle; one transaction is worked on at a time
// a finished result waits in the output register while the next input is taken
// reset (rst_n, asynchronous) restores register defaults, status open, filter unseeded

module ntc_thermistor_temperature_monitor #(
    parameter int SUPPLY_MV       = 3300,
    parameter int NOMINAL_TEMP_CK = 29815
) (
    input  logic          clk,
    input  logic          rst_n,
    ntcm_in_if.sink       in_ch,
    ntcm_out_if.source    out_ch,
    ntcm_cfg_if.sink      cfg
);

    localparam logic [11:0] SUPPLY_W  = 12'(SUPPLY_MV);
    localparam logic [15:0] T0_W      = 16'(NOMINAL_TEMP_CK);
    localparam logic [21:0] C100T0    = 22'(100 * NOMINAL_TEMP_CK);
    localparam int          FRAC_BITS = 28;
    localparam int          DIV_BITS  = 56;
    localparam logic [5:0]  LOG_LAST  = 6'(FRAC_BITS - 1);
    localparam logic [5:0]  DIV_LAST  = 6'(DIV_BITS - 1);

    // configuration registers
    logic [11:0]        open_thr_reg;
    logic [11:0]        short_thr_reg;
    logic signed [15:0] min_temp_reg;
    logic signed [15:0] max_temp_reg;
    logic [15:0]        interval_reg;
    logic [15:0]        alpha_reg;
    logic [15:0]        beta_reg;
    logic [23:0]        ratio_reg;

    // filter state
    logic signed [31:0] ema_reg, ema_next;
    logic signed [15:0] temp_reg, temp_next;
    logic [1:0]         status_reg, status_next;
    logic               seeded_reg, seeded_next;
    logic [31:0]        last_reg, last_next;

    // sequencer
    ntcm_pkg::state_t   state_reg, state_next;
    ntcm_pkg::log_sel_t log_sel_reg, log_sel_next;
    logic [5:0]         cnt_reg, cnt_next;

    // transaction being worked on
    logic [31:0]        now_reg, now_next;
    logic [11:0]        mv_reg, mv_next;
    logic               taken_reg, taken_next;
    logic [1:0]         pend_reg, pend_next;

    // datapath
    logic [30:0]        m_reg, m_next;
    logic [4:0]         n_reg, n_next;
    logic [27:0]        frac_reg, frac_next;
    logic signed [35:0] l_reg, l_next;
    logic signed [35:0] ln_reg, ln_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [47:0] den_reg, den_next;
    logic [55:0]        dvd_reg, dvd_next;
    logic [47:0]        rem_reg, rem_next;
    logic signed [32:0] diff_reg, diff_next;
    logic signed [31:0] ema_new_reg, ema_new_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic signed [15:0] out_temp_reg, out_temp_next;
    logic               out_taken_reg, out_taken_next;
    logic [31:0]        out_last_reg, out_last_next;

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;

    logic               in_acc;
    logic               cfg_acc;
    logic [31:0]        elapsed;
    logic [11:0]        rest;
    logic signed [35:0] lval;
    logic [31:0]        sq;
    logic signed [65:0] rnd;
    logic [48:0]        rem_sh;
    logic signed [57:0] cval;
    logic signed [31:0] cq;
    logic signed [32:0] tsum;
    logic [22:0]        beta100;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign cfg_acc = cfg.valid && cfg.ready;
    assign in_ch.ready = (state_reg == ntcm_pkg::S_IDLE);
    assign cfg.ready   = 1'b1;

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.sensor_status  = out_status_reg;
    assign out_ch.temp_centi_c   = out_temp_reg;
    assign out_ch.sample_taken   = out_taken_reg;
    assign out_ch.last_sample_ms = out_last_reg;

    assign elapsed = in_ch.now_ms - last_reg;
    assign rest    = SUPPLY_W - mv_reg;
    assign lval    = $signed({3'b000, n_reg, frac_reg});
    assign sq      = prod_reg[61:30];
    assign rem_sh  = {rem_reg, dvd_reg[55]};
    assign cval    = $signed({2'b00, dvd_reg}) - $signed({42'd0, ntcm_pkg::ZERO_C_CK});
    assign cq      = $signed({cval[15:0], 16'h0000});
    assign beta100 = 23'(beta_reg) * 23'd100;
    assign tsum    = $signed({ema_new_reg[31], ema_new_reg}) + 33'sd32768;

    // shared multiplier: operands picked by the sequencer, product registered
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ntcm_pkg::S_LOG_MUL:
            begin
                mul_a = $signed({2'b00, m_reg});
                mul_b = $signed({2'b00, m_reg});
            end
            ntcm_pkg::S_LN_A:
            begin
                mul_a = $signed({17'd0, l_reg[15:0]});
                mul_b = $signed({5'd0, ntcm_pkg::LN2_Q28});
            end
            ntcm_pkg::S_LN_B:
            begin
                // upper part of l carries the sign
                mul_a = $signed({{13{l_reg[35]}}, l_reg[35:16]});
                mul_b = $signed({5'd0, ntcm_pkg::LN2_Q28});
            end
            ntcm_pkg::S_DEN_A:
            begin
                mul_a = $signed({17'd0, ln_reg[15:0]});
                mul_b = $signed({17'd0, T0_W});
            end
            ntcm_pkg::S_DEN_B:
            begin
                mul_a = $signed({{13{ln_reg[35]}}, ln_reg[35:16]});
                mul_b = $signed({17'd0, T0_W});
            end
            ntcm_pkg::S_NUM_A:
            begin
                mul_a = $signed({11'd0, C100T0});
                mul_b = $signed({17'd0, beta_reg});
            end
            ntcm_pkg::S_EMA_A:
            begin
                mul_a = $signed({17'd0, alpha_reg});
                mul_b = diff_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        log_sel_next    = log_sel_reg;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        mv_next         = mv_reg;
        taken_next      = taken_reg;
        pend_next       = pend_reg;
        m_next          = m_reg;
        n_next          = n_reg;
        frac_next       = frac_reg;
        l_next          = l_reg;
        ln_next         = ln_reg;
        acc_next        = acc_reg;
        den_next        = den_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        diff_next       = diff_reg;
        ema_new_next    = ema_new_reg;
        ema_next        = ema_reg;
        temp_next       = temp_reg;
        status_next     = status_reg;
        seeded_next     = seeded_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_temp_next   = out_temp_reg;
        out_taken_next  = out_taken_reg;
        out_last_next   = out_last_reg;
        rnd             = '0;

        case (state_reg)
            ntcm_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    now_next = in_ch.now_ms;
                    mv_next  = in_ch.sample_mv;
                    if (seeded_reg && (elapsed < {16'd0, interval_reg}))
                    begin
                        // too soon after the last sample
                        taken_next = 1'b0;
                        state_next = ntcm_pkg::S_DONE;
                    end
                    else
                    begin
                        taken_next = 1'b1;
                        state_next = ntcm_pkg::S_DONE;
                        if (in_ch.sample_mv <= open_thr_reg)
                            pend_next = ntcm_pkg::ST_OPEN;
                        else if (in_ch.sample_mv >= short_thr_reg)
                            pend_next = ntcm_pkg::ST_SHORT;
                        else if (in_ch.sample_mv >= SUPPLY_W || ratio_reg == '0
                                 || in_ch.sample_mv == '0)
                            pend_next = ntcm_pkg::ST_RANGE;  // non-physical resistance
                        else
                        begin
                            log_sel_next = ntcm_pkg::LOG_RATIO;
                            state_next   = ntcm_pkg::S_LOG_INIT;
                        end
                    end
                end
            end

            ntcm_pkg::S_LOG_INIT:
            begin
                case (log_sel_reg)
                    ntcm_pkg::LOG_RATIO: m_next = {7'd0, ratio_reg};
                    ntcm_pkg::LOG_REST:  m_next = {19'd0, rest};
                    default:             m_next = {19'd0, mv_reg};
                endcase
                n_next     = 5'd30;
                frac_next  = '0;
                state_next = ntcm_pkg::S_LOG_NORM;
            end

            // one bit of normalising shift per cycle
            ntcm_pkg::S_LOG_NORM:
            begin
                if (!m_reg[30])
                begin
                    m_next = {m_reg[29:0], 1'b0};
                    n_next = n_reg - 5'd1;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ntcm_pkg::S_LOG_MUL;
                end
            end

            ntcm_pkg::S_LOG_MUL:
            begin
                state_next = ntcm_pkg::S_LOG_SQ;
            end

            // squared mantissa at or above two gives a one bit
            ntcm_pkg::S_LOG_SQ:
            begin
                m_next    = sq[31] ? sq[31:1] : sq[30:0];
                frac_next = {frac_reg[26:0], sq[31]};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == LOG_LAST)
                    state_next = ntcm_pkg::S_LOG_ACC;
                else
                    state_next = ntcm_pkg::S_LOG_MUL;
            end

            ntcm_pkg::S_LOG_ACC:
            begin
                case (log_sel_reg)
                    ntcm_pkg::LOG_RATIO:
                    begin
                        l_next       = lval - (36'sd16 <<< FRAC_BITS);
                        log_sel_next = ntcm_pkg::LOG_REST;
                        state_next   = ntcm_pkg::S_LOG_INIT;
                    end
                    ntcm_pkg::LOG_REST:
                    begin
                        l_next       = l_reg + lval;
                        log_sel_next = ntcm_pkg::LOG_MV;
                        state_next   = ntcm_pkg::S_LOG_INIT;
                    end
                    default:
                    begin
                        l_next     = l_reg - lval;
                        state_next = ntcm_pkg::S_LN_A;
                    end
                endcase
            end

            // ln = round(l * ln2), in two partial products
            ntcm_pkg::S_LN_A:
            begin
                state_next = ntcm_pkg::S_LN_B;
            end

            ntcm_pkg::S_LN_B:
            begin
                acc_next   = prod_reg;
                state_next = ntcm_pkg::S_LN_C;
            end

            ntcm_pkg::S_LN_C:
            begin
                acc_next   = acc_reg + (prod_reg <<< 16);
                state_next = ntcm_pkg::S_LN_D;
            end

            ntcm_pkg::S_LN_D:
            begin
                rnd        = acc_reg + 66'sd134217728;
                ln_next    = rnd[63:28];
                state_next = ntcm_pkg::S_DEN_A;
            end

            // den = round((100 B 2^28 + T0 ln) / 2^12)
            ntcm_pkg::S_DEN_A:
            begin
                state_next = ntcm_pkg::S_DEN_B;
            end

            ntcm_pkg::S_DEN_B:
            begin
                acc_next   = ($signed({43'd0, beta100}) <<< FRAC_BITS) + prod_reg;
                state_next = ntcm_pkg::S_DEN_C;
            end

            ntcm_pkg::S_DEN_C:
            begin
                acc_next   = acc_reg + (prod_reg <<< 16);
                state_next = ntcm_pkg::S_DEN_D;
            end

            ntcm_pkg::S_DEN_D:
            begin
                rnd        = acc_reg + 66'sd2048;
                den_next   = rnd[59:12];
                state_next = ntcm_pkg::S_NUM_A;
            end

            ntcm_pkg::S_NUM_A:
            begin
                if (den_reg <= 48'sd0)
                begin
                    pend_next  = ntcm_pkg::ST_RANGE;
                    state_next = ntcm_pkg::S_DONE;
                end
                else
                    state_next = ntcm_pkg::S_NUM_B;
            end

            // dividend = 100 T0 B 2^16 + den / 2
            ntcm_pkg::S_NUM_B:
            begin
                dvd_next   = {prod_reg[39:0], 16'h0000} + {9'd0, den_reg[47:1]};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ntcm_pkg::S_DIV;
            end

            // restoring divide, one quotient bit per cycle
            ntcm_pkg::S_DIV:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = 48'(rem_sh - {1'b0, den_reg});
                    dvd_next = {dvd_reg[54:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[47:0];
                    dvd_next = {dvd_reg[54:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = ntcm_pkg::S_WIN;
            end

            ntcm_pkg::S_WIN:
            begin
                if (cval < 58'(min_temp_reg) || cval > 58'(max_temp_reg))
                begin
                    pend_next  = ntcm_pkg::ST_RANGE;
                    state_next = ntcm_pkg::S_DONE;
                end
                else if (!seeded_reg)
                begin
                    ema_new_next = cq;
                    pend_next    = ntcm_pkg::ST_OK;
                    state_next   = ntcm_pkg::S_DONE;
                end
                else
                begin
                    diff_next  = $signed({cq[31], cq}) - $signed({ema_reg[31], ema_reg});
                    state_next = ntcm_pkg::S_EMA_A;
                end
            end

            ntcm_pkg::S_EMA_A:
            begin
                state_next = ntcm_pkg::S_EMA_B;
            end

            ntcm_pkg::S_EMA_B:
            begin
                rnd          = prod_reg + 66'sd32768;
                ema_new_next = ema_reg + $signed(rnd[47:16]);
                pend_next    = ntcm_pkg::ST_OK;
                state_next   = ntcm_pkg::S_DONE;
            end

            // commit the filter state of a taken sample and hand the result to the output register
            ntcm_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    if (taken_reg)
                    begin
                        last_next   = now_reg;
                        status_next = pend_reg;
                        if (pend_reg == ntcm_pkg::ST_OK)
                        begin
                            ema_next    = ema_new_reg;
                            seeded_next = 1'b1;
                            temp_next   = tsum[31:16];
                        end
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = status_next;
                    out_temp_next   = temp_next;
                    out_taken_next  = taken_reg;
                    out_last_next   = last_next;
                    state_next      = ntcm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ntcm_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ntcm_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            ema_reg       <= '0;
            temp_reg      <= '0;
            status_reg    <= ntcm_pkg::ST_OPEN;
            seeded_reg    <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ema_reg       <= ema_next;
            temp_reg      <= temp_next;
            status_reg    <= status_next;
            seeded_reg    <= seeded_next;
            last_reg      <= last_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_thr_reg  <= 12'd50;
            short_thr_reg <= 12'd3250;
            min_temp_reg  <= -16'sd4000;
            max_temp_reg  <= 16'sd12500;
            interval_reg  <= 16'd1000;
            alpha_reg     <= 16'd6554;
            beta_reg      <= 16'd3950;
            ratio_reg     <= 24'd65536;
        end
        else if (cfg_acc)
        begin
            case (cfg.reg_index)
                ntcm_pkg::REG_OPEN_THR:  open_thr_reg  <= cfg.data[11:0];
                ntcm_pkg::REG_SHORT_THR: short_thr_reg <= cfg.data[11:0];
                ntcm_pkg::REG_MIN_TEMP:  min_temp_reg  <= $signed(cfg.data[15:0]);
                ntcm_pkg::REG_MAX_TEMP:  max_temp_reg  <= $signed(cfg.data[15:0]);
                ntcm_pkg::REG_INTERVAL:  interval_reg  <= cfg.data[15:0];
                ntcm_pkg::REG_ALPHA:     alpha_reg     <= cfg.data[15:0];
                ntcm_pkg::REG_BETA:      beta_reg      <= cfg.data[15:0];
                ntcm_pkg::REG_RATIO:     ratio_reg     <= cfg.data;
                default:                 ratio_reg     <= ratio_reg;
            endcase
        end
    end

    // payload and datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        log_sel_reg    <= log_sel_next;
        cnt_reg        <= cnt_next;
        now_reg        <= now_next;
        mv_reg         <= mv_next;
        taken_reg      <= taken_next;
        pend_reg       <= pend_next;
        m_reg          <= m_next;
        n_reg          <= n_next;
        frac_reg       <= frac_next;
        l_reg          <= l_next;
        ln_reg         <= ln_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        den_reg        <= den_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        diff_reg       <= diff_next;
        ema_new_reg    <= ema_new_next;
        out_status_reg <= out_status_next;
        out_temp_reg   <= out_temp_next;
        out_taken_reg  <= out_taken_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// File: hdl/ntcm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ntcm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_status,
    input logic [15:0] out_temp,
    input logic        out_taken,
    input logic [31:0] out_last
);

    logic [50:0] out_payload;

    assign out_payload = {out_status, out_temp, out_taken, out_last};

    // a transaction taken in makes the block busy
    `NTCM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // a result only appears after a busy cycle
    `NTCM_ASSERT_IMP(a_result_after_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))

    // stalled result stays offered
    `NTCM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // stalled result keeps its payload
    `NTCM_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_payload))

endmodule

bind ntc_thermistor_temperature_monitor ntcm_checker u_ntcm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.sensor_status),
    .out_temp   (out_ch.temp_centi_c),
    .out_taken  (out_ch.sample_taken),
    .out_last   (out_ch.last_sample_ms)
);

// File: dv/ntc_thermistor_temperature_monitor_tb.sv
`timescale 1ns / 1ps

module ntc_thermistor_temperature_monitor_tb;

    localparam int SUPPLY       = 3300;
    localparam int T0_CK        = 29815;
    localparam longint LN2_FIX  = 64'sd186065279;
    localparam int SETTLE_CYC   = 400;      // longer than the slowest conversion
    localparam int CYCLE_LIMIT  = 3000000;

    typedef struct packed {
        logic [ntcm_pkg::STATUS_W-1:0] status;
        logic [ntcm_pkg::TEMP_W-1:0]   temp;
        logic                          taken;
        logic [ntcm_pkg::TIME_W-1:0]   last;
    } reading_t;

    typedef enum logic { ROW_SAMPLE, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t      kind;
        logic [2:0]     idx;
        logic [23:0]    data;
        logic [31:0]    now;
        logic [11:0]    mv;
        bit             typed;
        reading_t       want;
    } row_t;

    logic clk;
    logic rst_n;

    ntcm_in_if  in_ch ();
    ntcm_out_if out_ch ();
    ntcm_cfg_if cfg ();

    ntc_thermistor_temperature_monitor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // mirror of the block's registers
    int unsigned open_thr, short_thr, interval, alpha, beta, ratio;
    int          min_t, max_t;

    // mirror of the block's state
    int          ema;
    logic [15:0] shown_temp;
    logic [1:0]  status;
    bit          seeded;
    logic [31:0] last_time;

    reading_t pending_readings[$];
    row_t     rows[$];
    int       fails;
    int       items_sent;
    int       readings_seen;
    int       cycles;
    bit       quiet;        // no idling on either side in the last part

    // clock and single reset at the start
    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // floor((x + half) / 2^s), halves toward plus infinity
    function automatic longint round_sh(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // truncated base-2 log in Q28 by repeated squaring
    function automatic longint log2_fix(longint unsigned u);
        int n;
        longint unsigned t, m;
        longint fr;
        n = 0;
        t = u;
        fr = 0;
        while (t > 1)
        begin
            t = t >> 1;
            n++;
        end
        m = u << (30 - n);
        for (int i = 0; i < 28; i++)
        begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return (longint'(n) <<< 28) + fr;
    endfunction

    // beta equation in centidegrees; returns 0 on a non-physical result
    function automatic bit beta_to_centi(int unsigned mv, output longint c);
        longint rest, l, ln, den, num;
        rest = SUPPLY - longint'(mv);
        c = 0;
        if (rest <= 0 || ratio == 0 || mv == 0)
            return 0;
        l = log2_fix(ratio) - (64'sd16 <<< 28) + log2_fix(rest) - log2_fix(mv);
        ln = round_sh(l * LN2_FIX, 28);
        den = (64'sd100 * longint'(beta)) * (64'sd1 <<< 28) + longint'(T0_CK) * ln;
        den = round_sh(den, 12);
        if (den <= 0)
            return 0;
        num = (64'sd100 * T0_CK * longint'(beta)) * (64'sd1 <<< 16);
        c = (num + den / 2) / den - 27315;
        return 1;
    endfunction

    // advance the mirrored state by one accepted sample
    function automatic reading_t monitor_step(logic [31:0] now, logic [11:0] mv);
        reading_t r;
        longint c, diff;
        bit taken;
        taken = !(seeded && (now - last_time) < interval);
        if (taken)
        begin
            last_time = now;
            if (mv <= open_thr)
                status = ntcm_pkg::ST_OPEN;
            else if (mv >= short_thr)
                status = ntcm_pkg::ST_SHORT;
            else if (!beta_to_centi(mv, c) || c < min_t || c > max_t)
                status = ntcm_pkg::ST_RANGE;
            else
            begin
                if (!seeded)
                begin
                    ema = int'(c * 65536);
                    seeded = 1'b1;
                end
                else
                begin
                    diff = c * 65536 - longint'(ema);
                    ema = int'(longint'(ema) + round_sh(longint'(alpha) * diff, 16));
                end
                shown_temp = 16'(round_sh(longint'(ema), 16));
                status = ntcm_pkg::ST_OK;
            end
        end
        r.status = status;
        r.temp = shown_temp;
        r.taken = taken;
        r.last = last_time;
        return r;
    endfunction

    function automatic void mirror_reg(logic [2:0] idx, logic [23:0] v);
        case (idx)
            ntcm_pkg::REG_OPEN_THR:  open_thr = v[11:0];
            ntcm_pkg::REG_SHORT_THR: short_thr = v[11:0];
            ntcm_pkg::REG_MIN_TEMP:  min_t = int'($signed(v[15:0]));
            ntcm_pkg::REG_MAX_TEMP:  max_t = int'($signed(v[15:0]));
            ntcm_pkg::REG_INTERVAL:  interval = v[15:0];
            ntcm_pkg::REG_ALPHA:     alpha = v[15:0];
            ntcm_pkg::REG_BETA:      beta = v[15:0];
            ntcm_pkg::REG_RATIO:     ratio = v[23:0];
            default: ;
        endcase
    endfunction

    // wait until every reading is back, then let a skipped sample drain too
    task automatic wait_drained();
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] v);
        cfg.valid <= 1'b1;
        cfg.reg_index <= idx;
        cfg.data <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        mirror_reg(idx, v);
    endtask

    // one sample transaction, with an optional idle burst in front
    task automatic send_sample(logic [31:0] now, logic [11:0] mv, bit typed, reading_t want);
        reading_t r;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.now_ms <= now;
        in_ch.sample_mv <= mv;
        do
            @(posedge clk);
        while (!in_ch.ready);
        r = monitor_step(now, mv);
        pending_readings.push_back(typed ? want : r);
        items_sent++;
    endtask

    function automatic void add_sample(logic [31:0] now, logic [11:0] mv);
        row_t w;
        w.kind = ROW_SAMPLE;
        w.now = now;
        w.mv = mv;
        w.typed = 1'b0;
        w.want = '0;
        rows.push_back(w);
    endfunction

    function automatic void add_known(logic [31:0] now, logic [11:0] mv, logic [1:0] st);
        row_t w;
        w.kind = ROW_SAMPLE;
        w.now = now;
        w.mv = mv;
        w.typed = 1'b1;
        w.want.status = st;
        w.want.temp = '0;
        w.want.taken = 1'b1;
        w.want.last = now;
        rows.push_back(w);
    endfunction

    function automatic void add_reg(logic [2:0] idx, logic [23:0] v);
        row_t w;
        w.kind = ROW_REG;
        w.idx = idx;
        w.data = v;
        w.typed = 1'b0;
        rows.push_back(w);
    endfunction

    // result side: random stall bursts, field by field comparison
    initial
    begin
        int stall;
        reading_t got, exp_r;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.status = out_ch.sensor_status;
                got.temp = out_ch.temp_centi_c;
                got.taken = out_ch.sample_taken;
                got.last = out_ch.last_sample_ms;
                readings_seen++;
                if (pending_readings.size() == 0)
                begin
                    $error("reading with nothing expected");
                    fails++;
                end
                else
                begin
                    exp_r = pending_readings.pop_front();
                    if (got.status !== exp_r.status)
                    begin
                        $error("sensor_status exp %0d got %0d", exp_r.status, got.status);
                        fails++;
                    end
                    if (got.temp !== exp_r.temp)
                    begin
                        $error("temp_centi_c exp %0d got %0d",
                               $signed(exp_r.temp), $signed(got.temp));
                        fails++;
                    end
                    if (got.taken !== exp_r.taken)
                    begin
                        $error("sample_taken exp %0d got %0d", exp_r.taken, got.taken);
                        fails++;
                    end
                    if (got.last !== exp_r.last)
                    begin
                        $error("last_sample_ms exp %0h got %0h", exp_r.last, got.last);
                        fails++;
                    end
                end
            end
            if (stall > 0)
            begin
                stall--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 12) == 0)
            begin
                stall = $urandom_range(1, 11) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // stimulus
    initial
    begin
        logic [31:0] now;
        logic [11:0] mv;
        int unsigned lo, hi, pick;
        fails = 0;
        items_sent = 0;
        readings_seen = 0;
        cycles = 0;
        quiet = 1'b0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.now_ms <= '0;
        in_ch.sample_mv <= '0;
        cfg.valid <= 1'b0;
        cfg.reg_index <= ntcm_pkg::REG_OPEN_THR;
        cfg.data <= '0;

        // register defaults and state after reset
        open_thr = 50; short_thr = 3250; min_t = -4000; max_t = 12500;
        interval = 1000; alpha = 6554; beta = 3950; ratio = 65536;
        ema = 0; shown_temp = '0; status = ntcm_pkg::ST_OPEN; seeded = 1'b0; last_time = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: open and short edges before the filter is seeded
        add_known(32'd0, 12'd0, ntcm_pkg::ST_OPEN);
        add_known(32'd5, 12'd4095, ntcm_pkg::ST_SHORT);
        add_known(32'd10, 12'd50, ntcm_pkg::ST_OPEN);
        add_known(32'd20, 12'd3250, ntcm_pkg::ST_SHORT);
        add_sample(32'd30, 12'd1650);           // seeds near room temperature
        add_sample(32'd31, 12'd1000);           // inside interval, skipped
        add_sample(32'd1030, 12'd1000);
        add_sample(32'hFFFF_FFFF, 12'd2000);    // large elapsed time
        add_sample(32'h0000_03E6, 12'd2000);    // wrapped, 999 ms: skipped
        add_sample(32'h0000_03E8, 12'd60);      // wrapped, taken; very cold
        add_sample(32'h0000_07D0, 12'd3200);    // very hot
        // widest settings: thresholds out of the way, extreme constants
        add_reg(ntcm_pkg::REG_OPEN_THR, 24'd0);
        add_reg(ntcm_pkg::REG_SHORT_THR, 24'd4095);
        add_reg(ntcm_pkg::REG_MIN_TEMP, 24'h00954D);      // -27315
        add_reg(ntcm_pkg::REG_MAX_TEMP, 24'h007FFF);
        add_reg(ntcm_pkg::REG_INTERVAL, 24'd0);
        add_reg(ntcm_pkg::REG_ALPHA, 24'd65535);
        add_sample(32'h8000_0000, 12'd1);
        add_sample(32'h8000_0000, 12'd3299);
        add_sample(32'h8000_0001, 12'd3300);    // at supply: non-physical
        add_sample(32'h8000_0002, 12'd4094);    // above supply
        add_reg(ntcm_pkg::REG_BETA, 24'd65535);
        add_reg(ntcm_pkg::REG_RATIO, 24'hFFFFFF);
        add_sample(32'h8000_0003, 12'd1650);
        add_sample(32'h8000_0004, 12'd3000);
        // crossed thresholds, zero beta, zero ratio, inverted window
        add_reg(ntcm_pkg::REG_OPEN_THR, 24'd3000);
        add_reg(ntcm_pkg::REG_SHORT_THR, 24'd100);
        add_sample(32'h8000_0005, 12'd2000);    // open wins over short
        add_reg(ntcm_pkg::REG_OPEN_THR, 24'd10);
        add_reg(ntcm_pkg::REG_SHORT_THR, 24'd4000);
        add_reg(ntcm_pkg::REG_RATIO, 24'd0);
        add_sample(32'h8000_0006, 12'd1650);
        add_reg(ntcm_pkg::REG_RATIO, 24'd1);
        add_reg(ntcm_pkg::REG_BETA, 24'd0);
        add_sample(32'h8000_0007, 12'd1650);    // zero beta: denominator goes negative
        add_reg(ntcm_pkg::REG_BETA, 24'd3950);
        add_sample(32'h8000_0008, 12'd3);       // denominator stays positive, converted
        add_reg(ntcm_pkg::REG_ALPHA, 24'd0);
        add_reg(ntcm_pkg::REG_INTERVAL, 24'd65535);
        add_reg(ntcm_pkg::REG_RATIO, 24'd65536);
        add_sample(32'h8000_0009, 12'd1650);
        add_sample(32'h8001_0008, 12'd1700);    // 65535 ms later
        add_reg(ntcm_pkg::REG_MIN_TEMP, 24'h007FFF);
        add_reg(ntcm_pkg::REG_MAX_TEMP, 24'h00954D);
        add_sample(32'h8002_0008, 12'd1650);    // window empty

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_REG)
            begin
                in_ch.valid <= 1'b0;
                wait_drained();
                write_reg(rows[i].idx, rows[i].data);
            end
            else
                send_sample(rows[i].now, rows[i].mv, rows[i].typed, rows[i].want);
        end

        // random phases, each with its own register settings
        now = 32'h9000_0000;
        for (int ph = 0; ph < 10; ph++)
        begin
            in_ch.valid <= 1'b0;
            wait_drained();
            write_reg(ntcm_pkg::REG_OPEN_THR,
                      24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, 300)));
            write_reg(ntcm_pkg::REG_SHORT_THR,
                      24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(2900, 4095)));
            lo = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                           : 32'(16'(-$urandom_range(0, 27315)));
            hi = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 32767);
            write_reg(ntcm_pkg::REG_MIN_TEMP, 24'(lo));
            write_reg(ntcm_pkg::REG_MAX_TEMP, 24'(hi));
            write_reg(ntcm_pkg::REG_INTERVAL,
                      24'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 60)));
            write_reg(ntcm_pkg::REG_ALPHA, 24'($urandom_range(0, 65535)));
            write_reg(ntcm_pkg::REG_BETA,
                      24'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                      : $urandom_range(2000, 5000)));
            write_reg(ntcm_pkg::REG_RATIO,
                      24'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 24'hFFFFFF)
                                                      : $urandom_range(8192, 524288)));
            if (ph == 9)
                quiet = 1'b1;
            for (int k = 0; k < 86; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    now = $urandom;
                else if (pick < 3)
                    now = now + $urandom_range(0, interval);
                else
                    now = now + interval + $urandom_range(0, 40);
                if ($urandom_range(0, 4) == 0 || open_thr + 1 >= short_thr)
                    mv = 12'($urandom_range(0, 4095));
                else
                    mv = 12'($urandom_range(open_thr + 1, short_thr - 1));
                send_sample(now, mv, 1'b0, '0);
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        if (pending_readings.size() != 0)
        begin
            $error("readings still expected at the end: %0d", pending_readings.size());
            fails++;
        end
        $display("covered %0d samples and %0d readings over directed and 10 random setups",
                 items_sent, readings_seen);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
